// ===== design/wmd_pkg.sv =====
package wmd_pkg;

    // Config register indexes (byte address = 4 * index)
    localparam int unsigned      ADDR_W       = 4;
    localparam logic [1:0]       REG_START    = 2'd0;
    localparam logic [1:0]       REG_END      = 2'd1;
    localparam logic [1:0]       REG_MAX_LEN  = 2'd2;

    // Register reset values
    localparam logic [7:0]       START_CODE_RST = 8'd126;
    localparam logic [7:0]       END_CODE_RST   = 8'd231;
    localparam logic [15:0]      MAX_LEN_RST    = 16'd600;

    // Header window size
    localparam logic [2:0]       HDR_BYTES    = 3'd4;

    // Result kinds
    localparam logic [1:0]       KIND_PAYLOAD = 2'd0;
    localparam logic [1:0]       KIND_GOOD    = 2'd1;
    localparam logic [1:0]       KIND_BAD     = 2'd2;
    localparam logic [1:0]       KIND_NONE    = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_END     = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  end_code;
        logic [15:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  label;
        logic [15:0] byte_index;
        logic [7:0]  data;
    } t_result;

endpackage

// ===== design/wmd_ifs.sv =====
// Received byte channel
interface wmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result channel
interface wmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  label;
    logic [15:0] byte_index;
    logic [7:0]  data;

    modport source (output valid, output kind, output label, output byte_index,
                    output data, input ready);
    modport sink   (input valid, input kind, input label, input byte_index,
                    input data, output ready);
endinterface

// ===== design/wmd_apb_regs.sv =====
module wmd_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output wmd_pkg::t_cfg               o_cfg
);

    wmd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code <= wmd_pkg::START_CODE_RST;
            r_cfg.end_code   <= wmd_pkg::END_CODE_RST;
            r_cfg.max_length <= wmd_pkg::MAX_LEN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                wmd_pkg::REG_START:   r_cfg.start_code <= pwdata[7:0];
                wmd_pkg::REG_END:     r_cfg.end_code   <= pwdata[7:0];
                wmd_pkg::REG_MAX_LEN: r_cfg.max_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            wmd_pkg::REG_START:   prdata = {24'd0, r_cfg.start_code};
            wmd_pkg::REG_END:     prdata = {24'd0, r_cfg.end_code};
            wmd_pkg::REG_MAX_LEN: prdata = {16'd0, r_cfg.max_length};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/widget_message_deframer.sv =====
// Message deframer for a byte-serial link.
// i_rx carries one received byte per transaction. o_res carries one result
// per payload byte (kind payload, with label and byte position) and one per
// end byte (kind good or bad, byte_index = payload length, data = end byte).
// Header bytes give no result. The header is start code, label, length low,
// length high; a header with a wrong start code or a length above max_length
// is dropped one byte at a time while the window slides.
// Registers over the APB port: start_code (0x0), end_code (0x4),
// max_length (0x8); write them only while the block is idle.
// Throughput: one byte per cycle while the skid entry is empty.
// Results go to an output register backed by one skid entry, so a byte is
// still accepted while one result waits; i_rx.ready drops only when both
// entries are full and the receiver stalls.
// Reset (synchronous, active low) empties both entries, restarts header
// hunting with an empty window and loads the register defaults.
module widget_message_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wmd_in_if.sink                      i_rx,
    wmd_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    wmd_pkg::t_cfg     cfg;

    wmd_pkg::t_phase   r_phase,  n_phase;
    logic [7:0]        r_win [4];
    logic [7:0]        n_win [4];
    logic [2:0]        r_fill,   n_fill;
    logic [15:0]       r_len,    n_len;
    logic [15:0]       r_pos,    n_pos;
    logic [7:0]        r_label,  n_label;

    wmd_pkg::t_result  r_out,    r_skid, res;
    logic              r_out_valid, r_skid_valid;
    logic              has_res;
    logic              accept, pop;
    logic [15:0]       hdr_len;
    logic [15:0]       pos_inc;

    wmd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid & i_rx.ready;
    assign pop        = r_out_valid & o_res.ready;

    // Candidate length from the window after this byte shifts in
    assign hdr_len = {i_rx.rx_byte, r_win[3]};
    assign pos_inc = r_pos + 16'd1;

    // Next state and result for the byte on i_rx
    always_comb begin
        n_phase = r_phase;
        n_win   = r_win;
        n_fill  = r_fill;
        n_len   = r_len;
        n_pos   = r_pos;
        n_label = r_label;
        has_res = 1'b0;
        res     = '{kind: wmd_pkg::KIND_PAYLOAD, label: r_label,
                    byte_index: r_pos, data: i_rx.rx_byte};
        unique case (r_phase)
            wmd_pkg::PH_PAYLOAD: begin
                has_res = 1'b1;
                n_pos   = pos_inc;
                if (pos_inc >= r_len) begin
                    n_phase = wmd_pkg::PH_END;
                end
            end
            wmd_pkg::PH_END: begin
                has_res        = 1'b1;
                res.kind       = (i_rx.rx_byte == cfg.end_code) ?
                                 wmd_pkg::KIND_GOOD : wmd_pkg::KIND_BAD;
                res.byte_index = r_len;
                n_phase        = wmd_pkg::PH_HUNT;
                n_fill         = 3'd0;
                n_win          = '{default: 8'd0};
            end
            default: begin
                // Header hunting: slide the window by one byte
                n_phase  = wmd_pkg::PH_HUNT;
                n_win[0] = r_win[1];
                n_win[1] = r_win[2];
                n_win[2] = r_win[3];
                n_win[3] = i_rx.rx_byte;
                if (r_fill < wmd_pkg::HDR_BYTES) begin
                    n_fill = r_fill + 3'd1;
                end
                if (r_fill >= wmd_pkg::HDR_BYTES - 3'd1 &&
                    r_win[1] == cfg.start_code && hdr_len <= cfg.max_length) begin
                    n_label = r_win[2];
                    n_len   = hdr_len;
                    n_pos   = 16'd0;
                    n_fill  = 3'd0;
                    n_win   = '{default: 8'd0};
                    n_phase = (hdr_len == 16'd0) ? wmd_pkg::PH_END
                                                 : wmd_pkg::PH_PAYLOAD;
                end
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wmd_pkg::PH_HUNT;
            r_win   <= '{default: 8'd0};
            r_fill  <= 3'd0;
            r_len   <= 16'd0;
            r_pos   <= 16'd0;
            r_label <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_win   <= n_win;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_label <= n_label;
        end
    end

    // Output register plus one skid entry, in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (accept && has_res) begin
            if (!r_out_valid || pop) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.label      = r_out.label;
    assign o_res.byte_index = r_out.byte_index;
    assign o_res.data       = r_out.data;

endmodule

// ===== design/wmd_checker.sv =====
module wmd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_ready,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_res_kind
);

    // Nothing is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // Input stalls only while a result is held
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx_ready |-> i_res_valid)
        else $error("input stalled with no result pending");

    // Unused kind code never leaves the block
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_kind != wmd_pkg::KIND_NONE)
        else $error("illegal result kind");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

endmodule

bind widget_message_deframer wmd_checker u_wmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.kind)
);
